// ----- hw/rtl/ttx_pkg.sv -----
// Shared types and constants for the text terminal engine.
`default_nettype none
package ttx_pkg;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 6;
    localparam int CELL_W    = 13;
    localparam int COLOR_W   = 8;
    localparam int FUNC_W    = 4;
    localparam int IDX_W     = 11;
    localparam int CFG_IDX_W = 3;

    // command codes
    localparam logic [FUNC_W-1:0] FN_PRINT     = 4'd0;
    localparam logic [FUNC_W-1:0] FN_LEFT      = 4'd1;
    localparam logic [FUNC_W-1:0] FN_RIGHT     = 4'd2;
    localparam logic [FUNC_W-1:0] FN_UP        = 4'd3;
    localparam logic [FUNC_W-1:0] FN_DOWN      = 4'd4;
    localparam logic [FUNC_W-1:0] FN_BACKSPACE = 4'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 4'd6;
    localparam logic [FUNC_W-1:0] FN_CUR_ON    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_CUR_OFF   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_TICK      = 4'd9;
    localparam logic [FUNC_W-1:0] FN_READ      = 4'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd4;

    // special bytes
    localparam logic [7:0] SYM_CR     = 8'h0d;
    localparam logic [7:0] SYM_LF     = 8'h0a;
    localparam logic [7:0] SYM_TAB    = 8'h09;
    localparam logic [7:0] SYM_SPACE  = 8'h20;
    localparam logic [7:0] BLINK_MASK = 8'h80;
    localparam logic [1:0] TAB_MASK   = 2'b11;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] fg;
        logic [7:0] bg;
    } cell_t;

    typedef struct packed {
        logic [COL_W-1:0]   columns;
        logic [ROW_W-1:0]   rows;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [7:0]         interval;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] cursor_pos;
        cell_t            entry;
        logic             blinking;
    } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ttx_planes.sv -----
// Screen plane memory: character, foreground and background per cell.
`default_nettype none
module ttx_planes #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire ttx_pkg::cell_t   wdata,
    input  wire logic [AW-1:0]    raddr,
    output ttx_pkg::cell_t        rdata
);
    import ttx_pkg::*;

    cell_t mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/ttx_seq.sv -----
// Command sequencer: cursor tracking, scroll/backspace/clear sweeps, blink.
`default_nettype none
module ttx_seq #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32,
    parameter int AW          = 11
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_busy,
    input  wire logic [ttx_pkg::FUNC_W-1:0] func,
    input  wire logic [7:0]                 symbol,
    input  wire logic [ttx_pkg::IDX_W-1:0]  cell_index,
    input  wire ttx_pkg::cfg_t              cfg,
    input  wire logic                       geom_changed,
    input  wire logic                       res_free,
    output logic                            res_load,
    output ttx_pkg::res_t                   res,
    output logic                            mem_we,
    output logic [AW-1:0]                   mem_waddr,
    output ttx_pkg::cell_t                  mem_wdata,
    output logic [AW-1:0]                   mem_raddr,
    input  wire ttx_pkg::cell_t             mem_rdata
);
    import ttx_pkg::*;

    localparam int PLANE = MAX_COLUMNS * MAX_ROWS;
    localparam int XW    = AW + 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_GEOM   = 11'b00000000010,
        S_CHECK  = 11'b00000000100,
        S_DIVIDE = 11'b00000001000,
        S_EXEC   = 11'b00000010000,
        S_PUT    = 11'b00000100000,
        S_CP_RD  = 11'b00001000000,
        S_CP_WR  = 11'b00010000000,
        S_BLANK  = 11'b00100000000,
        S_RDWAIT = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [7:0]         sym_reg, sym_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [XW-1:0]      cursor_reg, cursor_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               dirty_reg, dirty_next;
    logic [XW-1:0]      cells_reg, cells_next;
    logic [XW-1:0]      src_reg, src_next;
    logic [XW-1:0]      dst_reg, dst_next;
    logic [XW-1:0]      end_reg, end_next;
    cell_t              saved_reg, saved_next;
    logic               blink_reg, blink_next;
    logic [7:0]         count_reg, count_next;
    cell_t              rd_reg, rd_next;

    logic [COL_W-1:0]   cols;
    logic [ROW_W-1:0]   rows;
    logic [ROW_W-1:0]   last_row;
    logic [XW-1:0]      colsx;
    logic [XW-1:0]      cursor_inc;
    logic [XW-1:0]      row_start;
    logic [COL_W-1:0]   col_inc;
    logic [COL_W-1:0]   adv_col;
    logic               col_wrap;
    logic               adv_end;
    logic               tab_mode;
    cell_t              blank;
    logic [7:0]         tick_ch;

    // clamped geometry and cursor arithmetic
    always_comb
    begin
        if (cfg.columns == '0)
            cols = COL_W'(1);
        else if (32'(cfg.columns) > MAX_COLUMNS)
            cols = COL_W'(MAX_COLUMNS);
        else
            cols = cfg.columns;

        if (cfg.rows < ROW_W'(2))
            rows = ROW_W'(2);
        else if (32'(cfg.rows) > MAX_ROWS)
            rows = ROW_W'(MAX_ROWS);
        else
            rows = cfg.rows;
    end

    assign last_row   = rows - ROW_W'(1);
    assign colsx      = XW'(cols);
    assign cursor_inc = cursor_reg + XW'(1);
    assign row_start  = cursor_reg - XW'(col_reg);
    assign col_inc    = col_reg + COL_W'(1);
    assign col_wrap   = (col_inc == cols);
    assign adv_col    = col_wrap ? '0 : col_inc;
    assign adv_end    = (cursor_inc == cells_reg);
    assign tab_mode   = (sym_reg == SYM_TAB);
    assign blank      = '{ch: SYM_SPACE, fg: cfg.fg, bg: cfg.bg};
    assign tick_ch    = mem_rdata.ch ^ BLINK_MASK;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        sym_next    = sym_reg;
        idx_next    = idx_reg;
        cursor_next = cursor_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        dirty_next  = dirty_reg | geom_changed;
        cells_next  = cells_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        end_next    = end_reg;
        saved_next  = saved_reg;
        blink_next  = blink_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        mem_we      = 1'b0;
        mem_waddr   = cursor_reg[AW-1:0];
        mem_wdata   = saved_reg;
        mem_raddr   = cursor_reg[AW-1:0];
        res_load    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next  = func;
                    sym_next   = symbol;
                    idx_next   = cell_index;
                    rd_next    = '0;
                    state_next = S_GEOM;
                end
            end

            S_GEOM:
            begin
                cells_next = XW'(CELL_W'(cols) * CELL_W'(rows));
                state_next = S_CHECK;
            end

            // cursor left beyond the screen or geometry rewritten
            S_CHECK:
            begin
                if (cursor_reg >= cells_reg)
                begin
                    cursor_next = cells_reg - XW'(1);
                    col_next    = cols - COL_W'(1);
                    row_next    = last_row;
                    dirty_next  = 1'b0;
                    state_next  = S_EXEC;
                end
                else if (dirty_reg)
                begin
                    src_next   = cursor_reg;
                    row_next   = '0;
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end

            // row/column by repeated subtraction
            S_DIVIDE:
            begin
                if (src_reg >= colsx)
                begin
                    src_next = src_reg - colsx;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next   = COL_W'(src_reg);
                    dirty_next = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (func_reg)
                    FN_PRINT:
                    begin
                        if (sym_reg == SYM_CR)
                        begin
                            cursor_next = row_start;
                            col_next    = '0;
                        end
                        else if (sym_reg == SYM_LF)
                        begin
                            col_next = '0;
                            if (row_reg == last_row)
                            begin
                                cursor_next = row_start;
                                dst_next    = '0;
                                src_next    = colsx;
                                end_next    = cells_reg;
                                state_next  = S_CP_RD;
                            end
                            else
                            begin
                                cursor_next = row_start + colsx;
                                row_next    = row_reg + ROW_W'(1);
                            end
                        end
                        else if (tab_mode)
                        begin
                            if ((col_reg[1:0] & TAB_MASK) != '0)
                                state_next = S_PUT;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end

                    FN_LEFT:
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - XW'(1);
                            if (col_reg == '0)
                            begin
                                col_next = cols - COL_W'(1);
                                row_next = row_reg - ROW_W'(1);
                            end
                            else
                            begin
                                col_next = col_reg - COL_W'(1);
                            end
                        end
                    end

                    FN_RIGHT:
                    begin
                        if (adv_end)
                        begin
                            cursor_next = cells_reg - colsx;
                            col_next    = '0;
                            dst_next    = '0;
                            src_next    = colsx;
                            end_next    = cells_reg;
                            state_next  = S_CP_RD;
                        end
                        else
                        begin
                            cursor_next = cursor_inc;
                            col_next    = adv_col;
                            if (col_wrap)
                                row_next = row_reg + ROW_W'(1);
                        end
                    end

                    FN_UP:
                    begin
                        if (row_reg != '0)
                        begin
                            cursor_next = cursor_reg - colsx;
                            row_next    = row_reg - ROW_W'(1);
                        end
                    end

                    FN_DOWN:
                    begin
                        if (row_reg == last_row)
                        begin
                            dst_next   = '0;
                            src_next   = colsx;
                            end_next   = cells_reg;
                            state_next = S_CP_RD;
                        end
                        else
                        begin
                            cursor_next = cursor_reg + colsx;
                            row_next    = row_reg + ROW_W'(1);
                        end
                    end

                    // shift rest of the row left, blank its last cell
                    FN_BACKSPACE:
                    begin
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - XW'(1);
                            dst_next    = cursor_reg - XW'(1);
                            src_next    = cursor_reg;
                            if (col_reg == '0)
                            begin
                                col_next = cols - COL_W'(1);
                                row_next = row_reg - ROW_W'(1);
                                end_next = cursor_reg;
                            end
                            else
                            begin
                                col_next = col_reg - COL_W'(1);
                                end_next = row_start + colsx;
                            end
                            state_next = S_CP_RD;
                        end
                    end

                    FN_CLEAR:
                    begin
                        cursor_next = '0;
                        col_next    = '0;
                        row_next    = '0;
                        dst_next    = '0;
                        src_next    = cells_reg;
                        end_next    = cells_reg;
                        state_next  = S_CP_RD;
                    end

                    FN_CUR_ON:
                    begin
                        state_next = S_RDWAIT;
                    end

                    FN_READ:
                    begin
                        mem_raddr  = AW'(idx_reg);
                        state_next = S_RDWAIT;
                    end

                    FN_CUR_OFF:
                    begin
                        blink_next = 1'b0;
                        mem_we     = 1'b1;
                        mem_wdata  = saved_reg;
                    end

                    FN_TICK:
                    begin
                        if (blink_reg)
                        begin
                            if (count_reg == '0)
                                state_next = S_RDWAIT;
                            else
                                count_next = count_reg - 8'd1;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // store one symbol and advance; repeats for tab padding
            S_PUT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{ch: (tab_mode ? SYM_SPACE : sym_reg), fg: cfg.fg, bg: cfg.bg};
                if (adv_end)
                begin
                    cursor_next = cells_reg - colsx;
                    col_next    = '0;
                    dst_next    = '0;
                    src_next    = colsx;
                    end_next    = cells_reg;
                    state_next  = S_CP_RD;
                end
                else
                begin
                    cursor_next = cursor_inc;
                    col_next    = adv_col;
                    if (col_wrap)
                        row_next = row_reg + ROW_W'(1);
                    if (tab_mode && ((adv_col[1:0] & TAB_MASK) != '0))
                        state_next = S_PUT;
                    else
                        state_next = S_DONE;
                end
            end

            // cell copy sweep: read source
            S_CP_RD:
            begin
                if (src_reg == end_reg)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    mem_raddr  = src_reg[AW-1:0];
                    state_next = S_CP_WR;
                end
            end

            // cell copy sweep: write destination
            S_CP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dst_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                src_next   = src_reg + XW'(1);
                dst_next   = dst_reg + XW'(1);
                state_next = S_CP_RD;
            end

            // blank fill up to the end mark
            S_BLANK:
            begin
                if (dst_reg == end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg[AW-1:0];
                    mem_wdata = blank;
                    dst_next  = dst_reg + XW'(1);
                end
            end

            S_RDWAIT:
            begin
                state_next = S_DONE;
                unique case (func_reg)
                    FN_CUR_ON:
                    begin
                        saved_next = mem_rdata;
                        blink_next = 1'b1;
                        count_next = '0;
                    end
                    FN_TICK:
                    begin
                        mem_we       = 1'b1;
                        mem_wdata.ch = tick_ch;
                        mem_wdata.fg = (tick_ch[7] != saved_reg.ch[7]) ? cfg.fg : saved_reg.fg;
                        mem_wdata.bg = mem_rdata.bg;
                        count_next   = cfg.interval - 8'd1;
                    end
                    default:
                    begin
                        if (32'(idx_reg) < PLANE)
                            rd_next = mem_rdata;
                    end
                endcase
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            dirty_reg  <= 1'b0;
            saved_reg  <= '0;
            blink_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            dirty_reg  <= dirty_next;
            saved_reg  <= saved_next;
            blink_reg  <= blink_next;
            count_reg  <= count_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        sym_reg   <= sym_next;
        idx_reg   <= idx_next;
        cells_reg <= cells_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        end_reg   <= end_next;
        rd_reg    <= rd_next;
    end

    assign cmd_busy       = (state_reg != S_IDLE);
    assign res.cursor_pos = IDX_W'(cursor_reg);
    assign res.entry      = rd_reg;
    assign res.blinking   = blink_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/text_terminal_engine.sv -----
// Text terminal engine top level: config registers, sequencer, planes, result register.
//
// Command channel (in_valid/in_stall) carries one word: func, symbol, cell_index.
// Result channel (out_valid/out_stall) returns one word per command: cursor_pos,
// the read cell (zero unless func is read) and the blinking flag.
// Configuration: cfg_we with cfg_index/cfg_data; the user must write it only while idle, the block does not enforce it.
// in_stall is high while a command is being worked; one command at a time.
// Flow: cursor moves that do not scroll, blink off and unused codes pass through
// GEOM, CHECK, EXEC and DONE before the result loads; a plain print adds PUT,
// and a read, cursor on or a toggling tick adds RDWAIT.
// After a columns/rows write the next command recomputes the cursor row by
// repeated subtraction, unless the cursor lies beyond the screen and is clamped.
// Scroll: each copied cell takes a read and then a write, then each blank a write,
// set by the single read and write port of the plane memory. Backspace copies
// the cells to the end of the row, and clear writes one blank per cell.
// A finished result waits in the output register while out_stall is high;
// the next command is still accepted and completes into the register once free.
// Reset: cursor at cell 0, blink off, registers at their defaults. Plane
// contents are undefined until cleared.
`default_nettype none
module text_terminal_engine #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ttx_pkg::FUNC_W-1:0]    func,
    input  wire logic [7:0]                    symbol,
    input  wire logic [ttx_pkg::IDX_W-1:0]     cell_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ttx_pkg::IDX_W-1:0]          cursor_pos,
    output logic [7:0]                         cell_char,
    output logic [7:0]                         cell_fg,
    output logic [7:0]                         cell_bg,
    output logic                               blinking,
    input  wire logic                          cfg_we,
    input  wire logic [ttx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data
);
    import ttx_pkg::*;

    localparam int PLANE = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(PLANE);

    cfg_t    cfg_reg;
    logic    geom_changed;
    logic    busy;
    logic    res_free;
    logic    res_load;
    res_t    res;
    res_t    out_reg;
    logic    out_valid_reg;
    logic    mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    cell_t   mem_wdata;
    cell_t   mem_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns  <= COL_W'(64);
            cfg_reg.rows     <= ROW_W'(32);
            cfg_reg.fg       <= 8'd1;
            cfg_reg.bg       <= 8'd0;
            cfg_reg.interval <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMNS:  cfg_reg.columns  <= cfg_data[COL_W-1:0];
                CFG_ROWS:     cfg_reg.rows     <= cfg_data[ROW_W-1:0];
                CFG_FG:       cfg_reg.fg       <= cfg_data;
                CFG_BG:       cfg_reg.bg       <= cfg_data;
                CFG_INTERVAL: cfg_reg.interval <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign geom_changed = cfg_we && ((cfg_index == CFG_COLUMNS) || (cfg_index == CFG_ROWS));

    ttx_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .AW          (AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (in_valid),
        .cmd_busy     (busy),
        .func         (func),
        .symbol       (symbol),
        .cell_index   (cell_index),
        .cfg          (cfg_reg),
        .geom_changed (geom_changed),
        .res_free     (res_free),
        .res_load     (res_load),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    ttx_planes #(
        .DEPTH (PLANE),
        .AW    (AW)
    ) u_planes (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result register
    assign res_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_reg <= res;
    end

    assign in_stall   = busy;
    assign out_valid  = out_valid_reg;
    assign cursor_pos = out_reg.cursor_pos;
    assign cell_char  = out_reg.entry.ch;
    assign cell_fg    = out_reg.entry.fg;
    assign cell_bg    = out_reg.entry.bg;
    assign blinking   = out_reg.blinking;

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the text terminal engine: directed and random commands checked against a predictor.
`timescale 1ns / 100ps
module tb;
    import ttx_pkg::*;

    localparam int PLANE       = 2048;
    localparam int CYCLE_LIMIT = 20000000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func;
    logic [7:0]           symbol;
    logic [IDX_W-1:0]     cell_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     cursor_pos;
    logic [7:0]           cell_char;
    logic [7:0]           cell_fg;
    logic [7:0]           cell_bg;
    logic                 blinking;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    text_terminal_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .symbol     (symbol),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_pos (cursor_pos),
        .cell_char  (cell_char),
        .cell_fg    (cell_fg),
        .cell_bg    (cell_bg),
        .blinking   (blinking),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // screen model state
    logic [7:0]  scr_ch [PLANE];
    logic [7:0]  scr_fg [PLANE];
    logic [7:0]  scr_bg [PLANE];
    int unsigned cur;
    logic [7:0]  sav_ch, sav_fg, sav_bg;
    logic        blink_act;
    logic [7:0]  blink_cnt;
    logic [6:0]  reg_cols;
    logic [5:0]  reg_rows;
    logic [7:0]  reg_fg, reg_bg, reg_interval;

    res_t        expected_words[$];
    int          mismatches;
    int unsigned cycles;
    bit          quiet;
    int unsigned stall_left;

    function automatic int unsigned eff_cols();
        if (reg_cols < 1) return 1;
        if (reg_cols > 64) return 64;
        return reg_cols;
    endfunction

    function automatic int unsigned eff_rows();
        if (reg_rows < 2) return 2;
        if (reg_rows > 32) return 32;
        return reg_rows;
    endfunction

    function automatic void blank_at(int unsigned i);
        if (i >= PLANE) return;
        scr_ch[i] = SYM_SPACE;
        scr_fg[i] = reg_fg;
        scr_bg[i] = reg_bg;
    endfunction

    function automatic void move_cell(int unsigned dst, int unsigned src);
        if (dst >= PLANE || src >= PLANE) return;
        scr_ch[dst] = scr_ch[src];
        scr_fg[dst] = scr_fg[src];
        scr_bg[dst] = scr_bg[src];
    endfunction

    function automatic void scroll_screen(int unsigned cols, int unsigned cells);
        int unsigned i;
        for (i = 0; i + cols < cells; i++)
            move_cell(i, i + cols);
        for (i = cells - cols; i < cells; i++)
            blank_at(i);
    endfunction

    function automatic void advance_cursor(int unsigned cols, int unsigned cells);
        if (cur >= cells)
        begin
            scroll_screen(cols, cells);
            cur -= cols;
        end
    endfunction

    function automatic void write_symbol(logic [7:0] s, int unsigned cols, int unsigned cells);
        if (cur < PLANE)
        begin
            scr_ch[cur] = s;
            scr_fg[cur] = reg_fg;
            scr_bg[cur] = reg_bg;
        end
        cur++;
        advance_cursor(cols, cells);
    endfunction

    // work out the result word of one command and update the screen model
    function automatic res_t terminal_result(logic [FUNC_W-1:0] f, logic [7:0] s,
                                             logic [IDX_W-1:0] idx);
        int unsigned cols, cells, pos;
        res_t r;
        cols  = eff_cols();
        cells = cols * eff_rows();
        r     = '0;
        if (cells > PLANE)
            cells = PLANE;
        if (cur >= cells)
            cur = cells - 1;
        case (f)
            FN_PRINT:
            begin
                if (s == SYM_CR)
                    cur -= cur % cols;
                else if (s == SYM_LF)
                begin
                    cur -= cur % cols;
                    if (cur / cols == eff_rows() - 1)
                        scroll_screen(cols, cells);
                    else
                        cur += cols;
                end
                else if (s == SYM_TAB)
                begin
                    while (((cur % cols) & TAB_MASK) != 0)
                        write_symbol(SYM_SPACE, cols, cells);
                end
                else
                    write_symbol(s, cols, cells);
            end
            FN_LEFT:
                if (cur > 0) cur--;
            FN_RIGHT:
            begin
                cur++;
                advance_cursor(cols, cells);
            end
            FN_UP:
                if (cur >= cols) cur -= cols;
            FN_DOWN:
            begin
                cur += cols;
                advance_cursor(cols, cells);
            end
            FN_BACKSPACE:
                if (cur > 0)
                begin
                    pos = cur;
                    cur--;
                    while ((pos % cols) != 0)
                    begin
                        move_cell(pos - 1, pos);
                        pos++;
                    end
                    blank_at(pos - 1);
                end
            FN_CLEAR:
            begin
                for (int unsigned i = 0; i < cells; i++)
                    blank_at(i);
                cur = 0;
            end
            FN_CUR_ON:
            begin
                sav_ch    = scr_ch[cur];
                sav_fg    = scr_fg[cur];
                sav_bg    = scr_bg[cur];
                blink_act = 1'b1;
                blink_cnt = '0;
            end
            FN_CUR_OFF:
            begin
                blink_act   = 1'b0;
                scr_ch[cur] = sav_ch;
                scr_fg[cur] = sav_fg;
                scr_bg[cur] = sav_bg;
            end
            FN_TICK:
                if (blink_act)
                begin
                    if (blink_cnt == 0)
                    begin
                        scr_ch[cur] ^= BLINK_MASK;
                        if ((scr_ch[cur] & BLINK_MASK) != (sav_ch & BLINK_MASK))
                            scr_fg[cur] = reg_fg;
                        else
                            scr_fg[cur] = sav_fg;
                        blink_cnt += reg_interval;
                    end
                    blink_cnt -= 1;
                end
            FN_READ:
                if (idx < PLANE)
                begin
                    r.entry.ch = scr_ch[idx];
                    r.entry.fg = scr_fg[idx];
                    r.entry.bg = scr_bg[idx];
                end
            default: ;
        endcase
        r.cursor_pos = cur[IDX_W-1:0];
        r.blinking   = blink_act;
        return r;
    endfunction

    // send one command word and queue its expected result
    task automatic send_cmd(logic [FUNC_W-1:0] f, logic [7:0] s, logic [IDX_W-1:0] idx);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        symbol     <= s;
        cell_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        expected_words.push_back(terminal_result(f, s, idx));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= v;
        @(posedge clk);
        case (ri)
            CFG_COLUMNS:  reg_cols     = v[6:0];
            CFG_ROWS:     reg_rows     = v[5:0];
            CFG_FG:       reg_fg       = v;
            CFG_BG:       reg_bg       = v;
            CFG_INTERVAL: reg_interval = v;
            default: ;
        endcase
    endtask

    // all five registers; clear the screen right after so every cell is written
    task automatic setup(logic [7:0] c, logic [7:0] r, logic [7:0] f, logic [7:0] b,
                         logic [7:0] iv);
        wait_idle();
        write_reg(CFG_COLUMNS, c);
        write_reg(CFG_ROWS, r);
        write_reg(CFG_FG, f);
        write_reg(CFG_BG, b);
        write_reg(CFG_INTERVAL, iv);
        cfg_we <= 1'b0;
        send_cmd(FN_CLEAR, 8'h00, '0);
    endtask

    task automatic random_cmd();
        int unsigned k;
        logic [7:0] s;
        k = $urandom_range(0, 99);
        s = 8'($urandom_range(0, 255));
        if (k < 35)
            send_cmd(FN_PRINT, s, IDX_W'($urandom_range(0, 2047)));
        else if (k < 45)
            send_cmd(FN_PRINT, (k < 38) ? SYM_CR : (k < 42) ? SYM_LF : SYM_TAB, '0);
        else if (k < 55)
            send_cmd(k[0] ? FN_LEFT : FN_RIGHT, s, '0);
        else if (k < 63)
            send_cmd(k[0] ? FN_UP : FN_DOWN, s, '0);
        else if (k < 70)
            send_cmd(FN_BACKSPACE, s, '0);
        else if (k < 71)
            send_cmd(FN_CLEAR, s, '0);
        else if (k < 75)
            send_cmd(FN_CUR_ON, s, '0);
        else if (k < 79)
            send_cmd(FN_CUR_OFF, s, '0);
        else if (k < 90)
            send_cmd(FN_TICK, s, '0);
        else if (k < 98)
            send_cmd(FN_READ, s, IDX_W'($urandom_range(0, 2047)));
        else
            send_cmd(FUNC_W'($urandom_range(11, 15)), s, IDX_W'($urandom_range(0, 2047)));
    endtask

    // full-size screen at reset values, print edge cases and special bytes
    task automatic test_print();
        send_cmd(FN_CLEAR, 8'h00, '0);
        send_cmd(FN_PRINT, 8'h00, '0);
        send_cmd(FN_PRINT, 8'hff, '0);
        send_cmd(FN_PRINT, 8'h41, '0);
        send_cmd(FN_PRINT, SYM_TAB, '0);
        send_cmd(FN_PRINT, SYM_CR, '0);
        send_cmd(FN_PRINT, SYM_LF, '0);
        send_cmd(FN_READ, 8'h00, 11'd1);
        send_cmd(FN_READ, 8'h00, 11'd2047);
    endtask

    // moves, backspace at cell 0 and at column 0, up on top row, unused codes
    task automatic test_cursor_moves();
        send_cmd(FN_CLEAR, 8'h00, '0);
        send_cmd(FN_BACKSPACE, 8'h00, '0);
        send_cmd(FN_UP, 8'h00, '0);
        send_cmd(FN_LEFT, 8'h00, '0);
        send_cmd(FN_DOWN, 8'h00, '0);
        send_cmd(FN_BACKSPACE, 8'h00, '0);
        send_cmd(FN_RIGHT, 8'h00, '0);
        send_cmd(4'd11, 8'hff, 11'h7ff);
        send_cmd(4'd15, 8'h00, '0);
    endtask

    // cursor off before on, blink toggles with interval 1, cursor on twice
    task automatic test_blink();
        setup(8'd4, 8'd2, 8'h5a, 8'ha5, 8'd1);
        send_cmd(FN_CUR_OFF, 8'h00, '0);
        send_cmd(FN_PRINT, 8'h7f, '0);
        send_cmd(FN_CUR_ON, 8'h00, '0);
        send_cmd(FN_CUR_ON, 8'h00, '0);
        repeat (3) send_cmd(FN_TICK, 8'h00, '0);
        send_cmd(FN_READ, 8'h00, 11'd1);
        send_cmd(FN_RIGHT, 8'h00, '0);
        send_cmd(FN_CUR_OFF, 8'h00, '0);
        send_cmd(FN_TICK, 8'h00, '0);
    endtask

    // random traffic across several geometries, clamped extremes included
    task automatic test_random_geometry();
        setup(8'd8, 8'd4, 8'hff, 8'h00, 8'd255);
        repeat (110) random_cmd();
        setup(8'd0, 8'd0, 8'h00, 8'hff, 8'd3);
        repeat (90) random_cmd();
        setup(8'd5, 8'd3, 8'h33, 8'hcc, 8'd2);
        repeat (110) random_cmd();
        setup(8'd127, 8'd63, 8'h01, 8'h00, 8'd20);
        repeat (40) random_cmd();
        setup(8'd1, 8'd5, 8'h81, 8'h7e, 8'd1);
        repeat (90) random_cmd();
        setup(8'd13, 8'd2, 8'h12, 8'h34, 8'd7);
        repeat (100) random_cmd();
    endtask

    // last stretch with no idling on either side
    task automatic test_quiet_tail();
        setup(8'd6, 8'd3, 8'h44, 8'h88, 8'd2);
        quiet = 1'b1;
        repeat (60) random_cmd();
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word, cursor %0d", cursor_pos);
            end
            else
            begin
                res_t e;
                e = expected_words.pop_front();
                if (cursor_pos !== e.cursor_pos || cell_char !== e.entry.ch ||
                    cell_fg !== e.entry.fg || cell_bg !== e.entry.bg ||
                    blinking !== e.blinking)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp cur %0d ch %h fg %h bg %h bl %b / got %0d %h %h %h %b",
                                 e.cursor_pos, e.entry.ch, e.entry.fg, e.entry.bg, e.blinking,
                                 cursor_pos, cell_char, cell_fg, cell_bg, blinking);
                end
            end
        end
    end

    // receiver stall bursts, started at random while not stalling
    always @(posedge clk)
    begin
        if (quiet || !rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!out_stall && $urandom_range(0, 6) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        in_valid     = 1'b0;
        func         = '0;
        symbol       = '0;
        cell_index   = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        quiet        = 1'b0;
        mismatches   = 0;
        cycles       = 0;
        cur          = 0;
        sav_ch       = '0;
        sav_fg       = '0;
        sav_bg       = '0;
        blink_act    = 1'b0;
        blink_cnt    = '0;
        reg_cols     = 7'd64;
        reg_rows     = 6'd32;
        reg_fg       = 8'd1;
        reg_bg       = 8'd0;
        reg_interval = 8'd20;
        for (int i = 0; i < PLANE; i++)
        begin
            scr_ch[i] = '0;
            scr_fg[i] = '0;
            scr_bg[i] = '0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_print();
        test_cursor_moves();
        test_blink();
        test_random_geometry();
        test_quiet_tail();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/ttx_pkg.sv
hw/rtl/ttx_planes.sv
hw/rtl/ttx_seq.sv
hw/rtl/text_terminal_engine.sv
verif/tb.sv
